@@ rtl/dle_alaw_receive_decoder_unit_macros.svh @@
// assertion helpers used by the checker file
`ifndef DLE_ALAW_RECEIVE_DECODER_UNIT_MACROS_SVH
`define DLE_ALAW_RECEIVE_DECODER_UNIT_MACROS_SVH

// implication checked only outside reset
`define DLEAD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked only outside reset
`define DLEAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define DLEAD_ASSERT_NEXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dlead_pkg.sv @@
package dlead_pkg;

  // line escape codes
  localparam logic [7:0] DLE_CODE = 8'h10;
  localparam logic [7:0] ETX_CODE = 8'h03;

  // result kinds
  localparam logic [1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [1:0] KIND_HANGUP  = 2'd1;
  localparam logic [1:0] KIND_CONTROL = 2'd2;

  // request types
  localparam logic REQ_BYTE  = 1'b0;
  localparam logic REQ_START = 1'b1;

  // one input word
  typedef struct packed {
    logic       req_type;
    logic [7:0] wire_byte;
  } in_word_t;

  // one result word
  typedef struct packed {
    logic signed [15:0] sample;
    logic [1:0]         kind;
    logic [7:0]         control_code;
  } out_word_t;

  // expand a bit-reversed a-law byte to a 16-bit linear sample
  function automatic logic signed [15:0] alaw_expand(input logic [7:0] wb);
    logic [7:0]  a;
    logic [2:0]  seg;
    logic [15:0] mag;
    logic [15:0] res;
    for (int i = 0; i < 8; i++) begin
      a[7-i] = wb[i];
    end
    a   = a ^ 8'h55;
    seg = a[6:4];
    mag = {8'd0, a[3:0], 4'd0};
    if (seg == 3'd0) begin
      mag = mag + 16'd8;
    end else begin
      mag = (mag + 16'h0108) << (seg - 3'd1);
    end
    res = a[7] ? mag : (16'd0 - mag);
    return $signed(res);
  endfunction

endpackage

@@ rtl/dlead_if.sv @@
// input channel: request type and line byte
interface dlead_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] wire_byte;

  modport source (output valid, output req_type, output wire_byte, input ready);
  modport sink   (input valid, input req_type, input wire_byte, output ready);
endinterface

// result channel: sample or control report
interface dlead_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] sample;
  logic [1:0]         kind;
  logic [7:0]         control_code;

  modport source (output valid, output sample, output kind, output control_code,
                  input ready);
  modport sink   (input valid, input sample, input kind, input control_code,
                  output ready);
endinterface

@@ rtl/dle_alaw_receive_decoder_unit.sv @@
// Receive decoder for an a-law line with DLE escaping.
// in_if carries one word per item: req_type (start request or line byte)
// and wire_byte. A start request puts the block online and drops any
// half-seen escape. While online, a plain byte becomes one expanded 16-bit
// sample, DLE DLE gives one sample of the escaped code, DLE ETX reports a
// hangup and goes offline, any other DLE pair reports a control code.
// Bytes seen while offline are dropped without a result.
// out_if carries sample, kind and control_code, at most one per word.
// A word taken from in_if passes the input register and then the result
// register before its result is on out_if.
// Throughput: one word per cycle while out_if.ready is high, set by the
// input and result registers with combinational decode between them.
// Reset (synchronous, rst_n low) empties both registers and leaves the
// block offline with no escape pending.
// When out_if.ready is low the result holds, one more word sits in the
// input register, and in_if.ready drops until the result is taken.
module dle_alaw_receive_decoder_unit (
  input  logic        clk,
  input  logic        rst_n,
  dlead_in_if.sink    in_if,
  dlead_out_if.source out_if
);
  import dlead_pkg::*;

  in_word_t  in_word;
  in_word_t  s1_word;
  logic      s1_valid;
  logic      s1_ready;
  out_word_t out_word;

  assign in_word.req_type  = in_if.req_type;
  assign in_word.wire_byte = in_if.wire_byte;

  // input register
  dlead_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .in_word  (in_word),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_word  (s1_word)
  );

  // decode and result register
  dlead_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_word   (s1_word),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_word  (out_word)
  );

  assign out_if.sample       = out_word.sample;
  assign out_if.kind         = out_word.kind;
  assign out_if.control_code = out_word.control_code;
endmodule

@@ rtl/dlead_in_stage.sv @@
module dlead_in_stage (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dlead_pkg::in_word_t in_word,
  output logic               s1_valid,
  input  logic               s1_ready,
  output dlead_pkg::in_word_t s1_word
);
  import dlead_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_word_t word_r;

  // take a new word whenever the register is empty or drains this cycle
  assign in_ready = !valid_r || s1_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= in_word;
    end
  end

  assign s1_valid = valid_r;
  assign s1_word  = word_r;
endmodule

@@ rtl/dlead_decode.sv @@
module dlead_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  output logic                s1_ready,
  input  dlead_pkg::in_word_t s1_word,
  output logic                out_valid,
  input  logic                out_ready,
  output dlead_pkg::out_word_t out_word
);
  import dlead_pkg::*;

  logic      online_r;
  logic      online_nxt;
  logic      esc_r;
  logic      esc_nxt;
  logic      adv;
  logic      res_valid;
  out_word_t res;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_word_t out_word_r;

  // word moves on when the result register is free or being read
  assign adv      = s1_valid && (!out_valid_r || out_ready);
  assign s1_ready = !out_valid_r || out_ready;

  // escape and online tracking, result selection
  always_comb begin
    online_nxt       = online_r;
    esc_nxt          = esc_r;
    res_valid        = 1'b0;
    res.sample       = '0;
    res.kind         = KIND_SAMPLE;
    res.control_code = '0;
    if (adv) begin
      if (s1_word.req_type == REQ_START) begin
        online_nxt = 1'b1;
        esc_nxt    = 1'b0;
      end else if (online_r) begin
        if (esc_r) begin
          esc_nxt   = 1'b0;
          res_valid = 1'b1;
          if (s1_word.wire_byte == DLE_CODE) begin
            res.sample = alaw_expand(DLE_CODE);
          end else if (s1_word.wire_byte == ETX_CODE) begin
            res.kind         = KIND_HANGUP;
            res.control_code = s1_word.wire_byte;
            online_nxt       = 1'b0;
          end else begin
            res.kind         = KIND_CONTROL;
            res.control_code = s1_word.wire_byte;
          end
        end else if (s1_word.wire_byte == DLE_CODE) begin
          esc_nxt = 1'b1;
        end else begin
          res_valid  = 1'b1;
          res.sample = alaw_expand(s1_word.wire_byte);
        end
      end
    end
  end

  // result register valid
  always_comb begin
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      online_r    <= 1'b0;
      esc_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      online_r    <= online_nxt;
      esc_r       <= esc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
endmodule

@@ rtl/dlead_checker.sv @@
`include "dle_alaw_receive_decoder_unit_macros.svh"

module dlead_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_sample,
  input logic [1:0]  out_kind,
  input logic [7:0]  out_control_code
);
  import dlead_pkg::*;

  // a stalled result stays put
  `DLEAD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_sample) && $stable(out_kind) && $stable(out_control_code), "result changed while stalled")

  // sample results carry no control code
  `DLEAD_ASSERT_IMP(a_sample_clean, out_valid && out_kind == KIND_SAMPLE, out_control_code == 8'd0, "sample result with control code")

  // hangup is always DLE ETX with a zero sample
  `DLEAD_ASSERT_IMP(a_hangup_etx, out_valid && out_kind == KIND_HANGUP, out_control_code == ETX_CODE && out_sample == 16'd0, "bad hangup report")

  // no result right after reset
  `DLEAD_ASSERT_NEXT_RST(a_reset_empty, !rst_n, !out_valid, "result valid after reset")
endmodule

bind dle_alaw_receive_decoder_unit dlead_checker u_dlead_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_sample       (out_if.sample),
  .out_kind         (out_if.kind),
  .out_control_code (out_if.control_code)
);

@@ tb/tb_dle_alaw_receive_decoder_unit.sv @@
module tb_dle_alaw_receive_decoder_unit;
  import dlead_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam int TAIL_CYCLES = 10;
  localparam int RANDOM_WORDS = 1150;

  logic clk = 1'b0;
  logic rst_n;

  dlead_in_if  in_ch ();
  dlead_out_if out_ch ();

  dle_alaw_receive_decoder_unit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  // predictor copy of the line state
  logic line_online = 1'b0;
  logic esc_seen = 1'b0;
  out_word_t expected_decodes[$];

  // run bookkeeping
  int errors = 0;
  int words_used = 0;
  int n_dropped = 0;
  int n_starts = 0;
  int n_samples = 0;
  int n_hangups = 0;
  int n_controls = 0;
  int quiet_cycles = 0;
  int hold_left = 0;
  bit no_gaps = 1'b0;

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // g.711 a-law expansion of a bit-reversed line byte, scaled to 16 bits
  function automatic logic signed [15:0] linear_from_wire(logic [7:0] wb);
    logic [7:0] code;
    int exp_seg;
    int level;
    for (int k = 0; k < 8; k++) code[k] = wb[7-k];
    code = code ^ 8'h55;
    exp_seg = int'(code[6:4]);
    level = int'(code[3:0]) * 16 + 8;
    if (exp_seg != 0) level = (level + 256) << (exp_seg - 1);
    return code[7] ? 16'(level) : 16'(-level);
  endfunction

  // update line state for one accepted word and queue its result, if any
  function automatic void predict_word(logic req, logic [7:0] b);
    out_word_t res;
    res = '0;
    res.kind = KIND_SAMPLE;
    if (req == REQ_START) begin
      line_online = 1'b1;
      esc_seen = 1'b0;
      n_starts++;
      words_used++;
      return;
    end
    if (!line_online) begin
      n_dropped++;
      return;
    end
    words_used++;
    if (esc_seen) begin
      esc_seen = 1'b0;
      if (b == DLE_CODE) begin
        res.sample = linear_from_wire(DLE_CODE);
      end else begin
        res.control_code = b;
        if (b == ETX_CODE) begin
          res.kind = KIND_HANGUP;
          line_online = 1'b0;
        end else begin
          res.kind = KIND_CONTROL;
        end
      end
    end else if (b == DLE_CODE) begin
      esc_seen = 1'b1;
      return;
    end else begin
      res.sample = linear_from_wire(b);
    end
    expected_decodes.push_back(res);
  endfunction

  // offer one word, with random gaps, and return at the edge that takes it
  task automatic put_word(input logic req, input logic [7:0] b);
    while (!no_gaps && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= req;
    in_ch.wire_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    predict_word(req, b);
  endtask

  task automatic put_byte(input logic [7:0] b);
    put_word(REQ_BYTE, b);
  endtask

  task automatic put_start();
    put_word(REQ_START, 8'($urandom));
  endtask

  // stop sending until every expected result has come out
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_decodes.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // receiver side: random stalls, calm stretches and long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ch.ready <= no_gaps || ($urandom_range(99) >= 6);
    end
  end

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin : check_results
    out_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_decodes.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: sample %0d kind %0d code %02h", $time,
                 out_ch.sample, out_ch.kind, out_ch.control_code);
      end else begin
        want = expected_decodes.pop_front();
        if (want.sample !== out_ch.sample) begin
          errors++;
          $display("%0t: sample expected %0d actual %0d", $time, want.sample,
                   out_ch.sample);
        end
        if (want.kind !== out_ch.kind) begin
          errors++;
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_ch.kind);
        end
        if (want.control_code !== out_ch.control_code) begin
          errors++;
          $display("%0t: control_code expected %02h actual %02h", $time,
                   want.control_code, out_ch.control_code);
        end
        case (want.kind)
          KIND_SAMPLE: n_samples++;
          KIND_HANGUP: n_hangups++;
          default:     n_controls++;
        endcase
      end
    end
  end

  // watchdog on cycles where neither side moves a word
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // bytes before any start must vanish
  task automatic test_offline_bytes();
    put_byte(DLE_CODE);
    put_byte(ETX_CODE);
    put_byte(8'h55);
    put_byte(8'hFF);
    wait_for_results();
  endtask

  // extremes of the plain byte, a lone etx is just audio
  task automatic test_plain_bytes();
    put_start();
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h01);
    put_byte(8'h80);
    put_byte(8'hD5);
    put_byte(ETX_CODE);
    wait_for_results();
  endtask

  // escaped dle, hangup, drop after hangup, control codes
  task automatic test_escape_pairs();
    put_byte(DLE_CODE);
    put_byte(DLE_CODE);
    put_byte(DLE_CODE);
    put_byte(ETX_CODE);
    put_byte(8'hAA);
    put_start();
    put_byte(DLE_CODE);
    put_byte(8'h00);
    put_byte(DLE_CODE);
    put_byte(8'hFF);
    put_byte(DLE_CODE);
    put_byte(8'h42);
    wait_for_results();
  endtask

  // start while online drops a half-seen escape
  task automatic test_start_online();
    put_byte(DLE_CODE);
    put_start();
    put_byte(8'h5A);
    put_word(REQ_START, 8'hFF);
    wait_for_results();
  endtask

  // receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    hold_left = 150;
    for (int i = 0; i < 60; i++) put_byte(8'($urandom));
    wait_for_results();
  endtask

  // random line traffic, mostly plain bytes with escape pairs and starts mixed in
  task automatic test_random_traffic();
    int goal;
    int pick;
    goal = words_used + RANDOM_WORDS;
    while (words_used < goal) begin
      // one calm stretch with no gaps on either side
      no_gaps = (words_used > goal - 800) && (words_used < goal - 600);
      pick = $urandom_range(99);
      if (!line_online) begin
        if (pick < 85) put_start();
        else put_byte(8'($urandom));
      end else if (pick < 70) begin
        put_byte(8'($urandom));
      end else if (pick < 80) begin
        put_byte(DLE_CODE);
        put_byte(8'($urandom));
      end else if (pick < 86) begin
        put_byte(DLE_CODE);
        put_byte(DLE_CODE);
      end else if (pick < 89) begin
        put_byte(DLE_CODE);
        put_byte(ETX_CODE);
      end else if (pick < 93) begin
        put_byte(DLE_CODE);
        put_start();
      end else if (pick < 96) begin
        put_start();
      end else begin
        put_byte(DLE_CODE);
        put_byte(8'($urandom_range(31)));
      end
    end
    no_gaps = 1'b0;
    wait_for_results();
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_BYTE;
    in_ch.wire_byte = 8'h00;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_offline_bytes();
    test_plain_bytes();
    test_escape_pairs();
    test_start_online();
    test_backpressure();
    test_random_traffic();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (expected_decodes.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never came out", $time,
               expected_decodes.size());
    end

    $display("run covered %0d line words (%0d start requests), %0d dropped offline",
             words_used, n_starts, n_dropped);
    $display("results seen: %0d samples, %0d hangups, %0d control codes",
             n_samples, n_hangups, n_controls);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
